// ===== rtl/hhd_pkg.sv =====
// Shared types and constants for the heading-hold differential drive.
`default_nettype none

package hhd_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SCALE  = 1'd1;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] GAIN_RESET  = 16'd1342;
  localparam logic [6:0]  SCALE_RESET = 7'd127;

  // Heading wrap limits, centidegrees
  localparam logic signed [17:0] HALF_TURN  = 18'sd18000;
  localparam logic signed [17:0] FULL_TURN  = 18'sd36000;
  localparam logic signed [17:0] TRIPLE_HALF = 18'sd54000;
  localparam logic signed [17:0] TWO_TURNS  = 18'sd72000;

  localparam int ONE_Q14    = 16384;
  localparam int GAIN_SHIFT = 12;

  // Quotient bits: |fwd -/+ w| <= den, so quotient <= drive_scale <= 127
  localparam int QBITS = 7;
  localparam int NUM_W = 23;

  typedef struct packed {
    logic signed [15:0] forward_cmd;
    logic [15:0]        target_heading;
    logic [15:0]        measured_heading;
  } hhd_in_t;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
  } hhd_out_t;

  // Mixer to divider: magnitudes, signs and common denominator
  typedef struct packed {
    logic [NUM_W-1:0] num_l;
    logic [NUM_W-1:0] num_r;
    logic             neg_l;
    logic             neg_r;
    logic [15:0]      den;
  } hhd_div_in_t;

  // Divider result
  typedef struct packed {
    logic [QBITS-1:0] q_l;
    logic [QBITS-1:0] q_r;
    logic             neg_l;
    logic             neg_r;
  } hhd_div_out_t;

endpackage

`default_nettype wire

// ===== rtl/hhd_err.sv =====
// Heading error wrap, gain multiply and turn clamp: three pipeline stages.
`default_nettype none

module hhd_err import hhd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire hhd_in_t           up_word,
  input  wire logic [15:0]       heading_gain,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output logic signed [15:0]     dn_fwd,
  output logic signed [15:0]     dn_turn
);

  localparam logic signed [20:0] TURN_MAX = 21'(ONE_Q14);
  localparam logic signed [20:0] TURN_MIN = -21'(ONE_Q14);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  logic signed [17:0] diff;
  logic signed [17:0] wrapped;
  logic signed [15:0] e1_err, e1_fwd;
  logic signed [32:0] e2_prod;
  logic signed [15:0] e2_fwd;
  logic signed [20:0] turn_raw;
  logic signed [20:0] turn_clamped;
  logic signed [15:0] e3_turn, e3_fwd;

  assign adv3     = !v3 || dn_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign up_ready = adv1;

  // At most two full-turn corrections are needed for 16-bit headings
  always_comb begin
    diff = $signed({2'b00, up_word.target_heading}) -
           $signed({2'b00, up_word.measured_heading});
    if (diff > TRIPLE_HALF) begin
      wrapped = diff - TWO_TURNS;
    end else if (diff > HALF_TURN) begin
      wrapped = diff - FULL_TURN;
    end else if (diff < -TRIPLE_HALF) begin
      wrapped = diff + TWO_TURNS;
    end else if (diff < -HALF_TURN) begin
      wrapped = diff + FULL_TURN;
    end else begin
      wrapped = diff;
    end
  end

  // Arithmetic shift gives floor division by 2^12
  always_comb begin
    turn_raw = e2_prod[32:GAIN_SHIFT];
    if (turn_raw > TURN_MAX) begin
      turn_clamped = TURN_MAX;
    end else if (turn_raw < TURN_MIN) begin
      turn_clamped = TURN_MIN;
    end else begin
      turn_clamped = turn_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= up_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      e1_err <= wrapped[15:0];
      e1_fwd <= up_word.forward_cmd;
    end
    if (adv2) begin
      e2_prod <= 33'(e1_err) * 33'($signed({1'b0, heading_gain}));
      e2_fwd  <= e1_fwd;
    end
    if (adv3) begin
      e3_turn <= turn_clamped[15:0];
      e3_fwd  <= e2_fwd;
    end
  end

  assign dn_valid = v3;
  assign dn_fwd   = e3_fwd;
  assign dn_turn  = e3_turn;

endmodule

`default_nettype wire

// ===== rtl/hhd_mix.sv =====
// Differential mix: denominator, side sums, magnitudes times drive scale.
`default_nettype none

module hhd_mix import hhd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire logic signed [15:0] up_fwd,
  input  wire logic signed [15:0] up_turn,
  input  wire logic [6:0]        drive_scale,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output hhd_div_in_t            dn_word
);

  logic v1, v2;
  logic adv1, adv2;

  logic signed [16:0] fwd_x;
  logic [16:0]        abs_f;
  logic [14:0]        abs_w;
  logic [16:0]        sum;
  logic [15:0]        den;
  logic signed [17:0] dl, dr;

  logic [15:0]        m1_den;
  logic signed [17:0] m1_dl, m1_dr;

  logic [16:0]        mag_l, mag_r;
  hhd_div_in_t        m2_word;

  assign adv2     = !v2 || dn_ready;
  assign adv1     = !v1 || adv2;
  assign up_ready = adv1;

  always_comb begin
    fwd_x = 17'(up_fwd);
    abs_f = fwd_x[16] ? 17'(-fwd_x) : 17'(fwd_x);
    abs_w = up_turn[15] ? 15'(-up_turn) : 15'(up_turn);
    sum   = abs_f + 17'(abs_w);
    den   = (sum < 17'(ONE_Q14)) ? 16'(ONE_Q14) : sum[15:0];
    dl    = 18'(up_fwd) - 18'(up_turn);
    dr    = 18'(up_fwd) + 18'(up_turn);
  end

  always_comb begin
    mag_l = m1_dl[17] ? 17'(-m1_dl) : 17'(m1_dl);
    mag_r = m1_dr[17] ? 17'(-m1_dr) : 17'(m1_dr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= up_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      m1_den <= den;
      m1_dl  <= dl;
      m1_dr  <= dr;
    end
    if (adv2) begin
      m2_word.num_l <= NUM_W'(mag_l[15:0]) * NUM_W'(drive_scale);
      m2_word.num_r <= NUM_W'(mag_r[15:0]) * NUM_W'(drive_scale);
      m2_word.neg_l <= m1_dl[17];
      m2_word.neg_r <= m1_dr[17];
      m2_word.den   <= m1_den;
    end
  end

  assign dn_valid = v2;
  assign dn_word  = m2_word;

endmodule

`default_nettype wire

// ===== rtl/hhd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, both sides.
`default_nettype none

module hhd_div import hhd_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         up_valid,
  output logic              up_ready,
  input  wire hhd_div_in_t  up_word,
  output logic              dn_valid,
  input  wire logic         dn_ready,
  output hhd_div_out_t      dn_word
);

  typedef struct packed {
    logic [NUM_W-1:0] rem_l;
    logic [NUM_W-1:0] rem_r;
    logic [QBITS-1:0] q_l;
    logic [QBITS-1:0] q_r;
    logic             neg_l;
    logic             neg_r;
    logic [15:0]      den;
  } hhd_div_st_t;

  logic [QBITS-1:0] v;
  logic [QBITS-1:0] adv;
  hhd_div_st_t      st  [QBITS];
  hhd_div_st_t      nxt [QBITS];

  always_comb begin
    adv[QBITS-1] = !v[QBITS-1] || dn_ready;
    for (int k = QBITS - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end
  assign up_ready = adv[0];

  // Stage k resolves quotient bit QBITS-1-k
  always_comb begin
    hhd_div_st_t      src;
    logic [NUM_W-1:0] dsh;
    logic [QBITS-1:0] qbit;
    for (int k = 0; k < QBITS; k++) begin
      if (k == 0) begin
        src.rem_l = up_word.num_l;
        src.rem_r = up_word.num_r;
        src.q_l   = '0;
        src.q_r   = '0;
        src.neg_l = up_word.neg_l;
        src.neg_r = up_word.neg_r;
        src.den   = up_word.den;
      end else begin
        src = st[(k > 0) ? k - 1 : 0];
      end
      dsh    = NUM_W'(src.den) << (QBITS - 1 - k);
      qbit   = QBITS'(1) << (QBITS - 1 - k);
      nxt[k] = src;
      if (src.rem_l >= dsh) begin
        nxt[k].rem_l = src.rem_l - dsh;
        nxt[k].q_l   = src.q_l | qbit;
      end
      if (src.rem_r >= dsh) begin
        nxt[k].rem_r = src.rem_r - dsh;
        nxt[k].q_r   = src.q_r | qbit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= up_valid;
      end
      for (int k = 1; k < QBITS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QBITS; k++) begin
      if (adv[k]) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign dn_valid      = v[QBITS-1];
  assign dn_word.q_l   = st[QBITS-1].q_l;
  assign dn_word.q_r   = st[QBITS-1].q_r;
  assign dn_word.neg_l = st[QBITS-1].neg_l;
  assign dn_word.neg_r = st[QBITS-1].neg_r;

endmodule

`default_nettype wire

// ===== rtl/heading_hold_differential_drive.sv =====
// Top level: heading-hold P controller with differential-drive mix.
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+------------------------------------
//  in      | in  | in_valid / in_stall    | forward_cmd, target/measured heading
//  out     | out | out_valid / out_stall  | left_drive, right_drive
//  cfg     | in  | cfg_we (no wait)       | cfg_index, cfg_data
//
//  One word in per cycle, one word out per cycle, unless out_stall backs up
//  the pipe; 3 error/turn stages, 2 mix stages, 7 divider stages, output register.
//  The 7-stage divider sets the depth: one quotient bit per stage.
//  rst (synchronous) empties every stage and restores gain 1342, scale 127.
//  Each stage moves when it is empty or the one after it moves, so bubbles
//  close up and input is taken while a finished word waits on out_stall.
`default_nettype none

module heading_hold_differential_drive import hhd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire hhd_in_t               in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output hhd_out_t                   out_word,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration; the user must change it only while the pipeline is empty (not enforced here)
  logic [15:0] heading_gain;
  logic [6:0]  drive_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_gain <= GAIN_RESET;
      drive_scale  <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADING_GAIN: heading_gain <= cfg_data;
        CFG_DRIVE_SCALE:  drive_scale  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Error wrap -> gain -> clamped turn
  logic               err_ready;
  logic               turn_valid, turn_ready;
  logic signed [15:0] turn_fwd, turn_w;

  hhd_err u_err (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (in_valid),
    .up_ready     (err_ready),
    .up_word      (in_word),
    .heading_gain (heading_gain),
    .dn_valid     (turn_valid),
    .dn_ready     (turn_ready),
    .dn_fwd       (turn_fwd),
    .dn_turn      (turn_w)
  );

  assign in_stall = !err_ready;

  // Mix into numerators and the shared normalizer
  logic        mix_valid, mix_ready;
  hhd_div_in_t mix_word;

  hhd_mix u_mix (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (turn_valid),
    .up_ready    (turn_ready),
    .up_fwd      (turn_fwd),
    .up_turn     (turn_w),
    .drive_scale (drive_scale),
    .dn_valid    (mix_valid),
    .dn_ready    (mix_ready),
    .dn_word     (mix_word)
  );

  // Magnitude divide, truncating toward zero
  logic         div_valid, div_ready;
  hhd_div_out_t div_word;

  hhd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mix_valid),
    .up_ready (mix_ready),
    .up_word  (mix_word),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_word  (div_word)
  );

  // Output register: restore sign
  logic [7:0] mag_l, mag_r;

  assign div_ready = !out_valid || !out_stall;
  assign mag_l     = {1'b0, div_word.q_l};
  assign mag_r     = {1'b0, div_word.q_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (div_ready) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      out_word.left_drive  <= div_word.neg_l ? 8'(-mag_l) : mag_l;
      out_word.right_drive <= div_word.neg_r ? 8'(-mag_r) : mag_r;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for the heading-hold differential-drive block.
`timescale 1ns / 1ps

module tb_top;
  import hhd_pkg::*;

  // Cycles with no word moving on either side before the run is declared hung.
  // Slowest legal gap: pipeline fill, config writes, random stalls.
  localparam int HANG_LIMIT = 2000;
  // Drain time after the last result.
  localparam int DRAIN_CYCLES = 20;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  hhd_in_t               in_word = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  hhd_out_t              out_word;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Words waiting to be sent, and drive commands waiting to come out.
  hhd_in_t  pending_words[$];
  hhd_out_t drive_expected[$];

  // Our copy of the register file, tracked as we write it.
  logic [15:0] gain_now = GAIN_RESET;
  logic [6:0]  scale_now = SCALE_RESET;

  // Idle/stall rates in percent, changed per phase.
  int gap_pct = 8;
  int stall_pct = 8;

  int mismatch_count = 0;
  int hang_cycles = 0;

  heading_hold_differential_drive i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Heading error -> P turn -> normalized differential mix.
  function automatic hhd_out_t predict_drive(hhd_in_t word, logic [15:0] gain,
                                             logic [6:0] scale);
    longint fwd;
    longint err;
    longint g;
    longint s;
    longint turn;
    longint den;
    longint left_q;
    longint right_q;
    hhd_out_t res;
    fwd = $signed(word.forward_cmd);
    err = longint'(word.target_heading) - longint'(word.measured_heading);
    g = gain;
    s = scale;
    // wrap into -18000..18000; the end points themselves stay put
    while (err > 18000) err -= 36000;
    while (err < -18000) err += 36000;
    // arithmetic shift on a signed value floors, as the turn needs
    turn = (err * g) >>> GAIN_SHIFT;
    if (turn > ONE_Q14) turn = ONE_Q14;
    if (turn < -ONE_Q14) turn = -ONE_Q14;
    den = (fwd < 0 ? -fwd : fwd) + (turn < 0 ? -turn : turn);
    if (den < ONE_Q14) den = ONE_Q14;
    // signed division truncates toward zero
    left_q = ((fwd - turn) * s) / den;
    right_q = ((fwd + turn) * s) / den;
    res.left_drive = left_q[7:0];
    res.right_drive = right_q[7:0];
    return res;
  endfunction

  // Driver: hold a word until it is taken, then maybe idle before the next.
  always @(posedge clk) begin : drive_inputs
    logic taken;
    taken = in_valid && !in_stall;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) begin
        drive_expected.insert(drive_expected.size(),
                              predict_drive(in_word, gain_now, scale_now));
      end
      if (!in_valid || taken) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= gap_pct) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %0s expected %0d got %0d", $time, field,
               $signed(want), $signed(got));
    end
  endtask

  // Monitor: compare each word taken against the oldest prediction.
  always @(posedge clk) begin : check_outputs
    hhd_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_expected.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: output word with nothing pending: left %0d right %0d",
                     $time, out_word.left_drive, out_word.right_drive);
          end
        end else begin
          want = drive_expected.pop_front();
          if (out_word.left_drive !== want.left_drive) begin
            note_mismatch("left_drive", want.left_drive, out_word.left_drive);
          end
          if (out_word.right_drive !== want.right_drive) begin
            note_mismatch("right_drive", want.right_drive, out_word.right_drive);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Hang detector: nothing moving on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Wait until every word is sent and every result has come back.
  task automatic wait_drained();
    while (pending_words.size() != 0 || drive_expected.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  // Register write; only called with the block drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_HEADING_GAIN: gain_now = data;
      CFG_DRIVE_SCALE:  scale_now = data[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [15:0] gain, input logic [15:0] scale_word,
                             input int gap, input int stall);
    wait_drained();
    write_reg(CFG_HEADING_GAIN, gain);
    write_reg(CFG_DRIVE_SCALE, scale_word);
    gap_pct = gap;
    stall_pct = stall;
  endtask

  task automatic queue_word(input logic [15:0] fwd, input logic [15:0] tgt,
                            input logic [15:0] meas);
    hhd_in_t word;
    word.forward_cmd = fwd;
    word.target_heading = tgt;
    word.measured_heading = meas;
    pending_words.insert(pending_words.size(), word);
  endtask

  // Mostly in-range commands and headings; some full 16-bit values, some
  // small errors so the turn lands near zero where flooring shows.
  task automatic queue_random(input int count);
    int pick;
    int f;
    int tgt;
    int meas;
    logic [31:0] raw;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        f = $urandom_range(32768);
        f = f - 16384;
      end else if (pick < 85) begin
        raw = $urandom();
        f = raw[15:0];
      end else begin
        case ($urandom_range(2))
          0: f = 16384;
          1: f = -16384;
          default: f = 0;
        endcase
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
        tgt = $urandom_range(35999);
        meas = $urandom_range(35999);
      end else if (pick < 90) begin
        raw = $urandom();
        tgt = raw[15:0];
        meas = raw[31:16];
      end else begin
        tgt = $urandom_range(35999);
        meas = tgt + $urandom_range(100) - 50;
      end
      queue_word(f[15:0], tgt[15:0], meas[15:0]);
    end
  endtask

  initial begin : run_test
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset register values, directed corners first.
    queue_word(16'sd0, 16'd0, 16'd0);
    queue_word(16'sd16384, 16'd1000, 16'd1000);
    queue_word(-16'sd16384, 16'd1000, 16'd1000);
    queue_word(16'sh7FFF, 16'd9000, 16'd0);        // forward beyond +1.0
    queue_word(16'sh8000, 16'd0, 16'd9000);        // forward beyond -1.0
    queue_word(16'sd0, 16'd18000, 16'd0);          // error exactly +half turn
    queue_word(16'sd0, 16'd0, 16'd18000);          // error exactly -half turn
    queue_word(16'sd8000, 16'd18001, 16'd0);       // just past +half, wraps
    queue_word(16'sd8000, 16'd0, 16'd18001);       // just past -half, wraps
    queue_word(16'sd16384, 16'd35999, 16'd0);      // wraps to -1
    queue_word(16'sd16384, 16'd0, 16'd35999);      // wraps to +1
    queue_word(16'sd0, 16'd0, 16'd1);              // -1 error floors to -1
    queue_word(-16'sd5000, 16'hFFFF, 16'd0);       // heading above 35999
    queue_word(16'sd5000, 16'd0, 16'hFFFF);
    queue_word(16'sd12345, 16'hFFFF, 16'hFFFF);
    queue_word(16'sd16384, 16'd30000, 16'd12000);  // big turn with full forward
    queue_random(150);

    // Max gain: turn clamps at +/-1.0.
    reconfigure(16'hFFFF, 16'd127, 8, 8);
    queue_word(16'sd16384, 16'd18000, 16'd0);
    queue_word(-16'sd16384, 16'd0, 16'd18000);
    queue_word(16'sd0, 16'd1, 16'd0);
    queue_word(16'sd0, 16'd0, 16'd1);
    queue_random(100);

    // Zero gain and zero scale: outputs must be zero.
    reconfigure(16'd0, 16'd0, 8, 8);
    queue_random(60);

    // Smallest non-zero settings.
    reconfigure(16'd1, 16'd1, 8, 8);
    queue_random(80);

    // Random settings, junk in the upper scale bits, and no idling at all.
    reconfigure(16'($urandom()), 16'hFF80 | 16'($urandom_range(127)), 0, 0);
    queue_random(200);

    // Back to the reset values, written explicitly.
    reconfigure(GAIN_RESET, {9'd0, SCALE_RESET}, 8, 8);
    queue_random(200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && drive_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hhd_pkg.sv
rtl/hhd_err.sv
rtl/hhd_mix.sv
rtl/hhd_div.sv
rtl/heading_hold_differential_drive.sv
dv/tb_top.sv
